/* rtl/mpt_pkg.sv */
// ----------------------------------------------------------------------------
// mpt_pkg: shared types and constants of the motion peak tracker
// Item modes, FIFO tags, register indexes, state codes and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mpt_pkg;

    localparam int AXIS_W     = 16;
    localparam int SQ_W       = 2 * AXIS_W;
    localparam int AXES       = 3;
    localparam int AXIS_SEL_W = $clog2(AXES);
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int TAG_W      = 5;

    localparam logic [AXIS_W-1:0] AGE_MAX   = '1;
    localparam logic [AXIS_W-1:0] COUNT_MAX = '1;

    localparam logic [TAG_W-1:0] TAG_RATE  = TAG_W'(1);
    localparam logic [TAG_W-1:0] TAG_ACCEL = TAG_W'(2);

    // configuration register indexes
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_FRESH  = 1'b1;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_STATUS = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_REPORT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_LOAD,
        ST_ROOT,
        ST_COMMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                  capture;
        logic                  mac;
        logic [AXIS_SEL_W-1:0] axis_sel;
        logic                  root_load;
        logic                  root_step;
        logic                  commit;
        logic                  status;
        logic                  tick;
        logic                  report;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  sample_ok;
        logic  out_full;
    } sts_t;

endpackage

/* rtl/mpt_isqrt.sv */
// ----------------------------------------------------------------------------
// mpt_isqrt: step-wise floor square root
// Restoring digit-by-digit root of a 32-bit operand, one result bit per step.
// ----------------------------------------------------------------------------
module mpt_isqrt (
    input  logic                          clk,
    input  logic                          load,
    input  logic                          step,
    input  logic [mpt_pkg::SQ_W-1:0]      operand,
    output logic [mpt_pkg::AXIS_W-1:0]    root
);
    import mpt_pkg::*;

    localparam logic [SQ_W-1:0] BIT_START = SQ_W'(1) << (SQ_W - 2);

    logic [SQ_W-1:0] rem_reg,  rem_next;
    logic [SQ_W-1:0] root_reg, root_next;
    logic [SQ_W-1:0] bit_reg,  bit_next;
    logic [SQ_W:0]   trial;

    // one trial subtraction per step
    always_comb
    begin
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (load)
        begin
            rem_next  = operand;
            root_next = '0;
            bit_next  = BIT_START;
        end
        else if (step)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next  = rem_reg - trial[SQ_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign root = root_reg[AXIS_W-1:0];

endmodule

/* rtl/mpt_dp.sv */
// ----------------------------------------------------------------------------
// mpt_dp: datapath of the motion peak tracker
// Holds configuration, latest axes, peaks, counts, ages and latches, forms
// the sum of squares, and owns the report output register.
// ----------------------------------------------------------------------------
module mpt_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpt_pkg::cmd_t                     cmd,
    output mpt_pkg::sts_t                     sts,
    input  logic                              write_en,
    input  logic                              reg_index,
    input  logic [mpt_pkg::AXIS_W-1:0]        write_data,
    input  logic [1:0]                        mode,
    input  logic [mpt_pkg::TAG_W-1:0]         tag,
    input  logic signed [mpt_pkg::AXIS_W-1:0] axis_x,
    input  logic signed [mpt_pkg::AXIS_W-1:0] axis_y,
    input  logic signed [mpt_pkg::AXIS_W-1:0] axis_z,
    input  logic                              overrun_flag,
    input  logic                              bus_error,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              report_valid,
    output logic signed [mpt_pkg::AXIS_W-1:0] accel_x,
    output logic signed [mpt_pkg::AXIS_W-1:0] accel_y,
    output logic signed [mpt_pkg::AXIS_W-1:0] accel_z,
    output logic signed [mpt_pkg::AXIS_W-1:0] rate_x,
    output logic signed [mpt_pkg::AXIS_W-1:0] rate_y,
    output logic signed [mpt_pkg::AXIS_W-1:0] rate_z,
    output logic [mpt_pkg::AXIS_W-1:0]        peak_accel_mag,
    output logic [mpt_pkg::AXIS_W-1:0]        peak_rate_mag,
    output logic [mpt_pkg::AXIS_W-1:0]        accel_samples,
    output logic                              fifo_overrun
);
    import mpt_pkg::*;

    localparam logic [AXIS_W-1:0] FRESH_RESET = AXIS_W'(200);

    // configuration
    logic              enable_reg;
    logic [AXIS_W-1:0] fresh_reg;

    // sample in flight
    logic                     is_accel_reg;
    logic signed [AXIS_W-1:0] axis_reg [AXES];
    logic [SQ_W-1:0]          acc_reg;
    logic signed [AXIS_W-1:0] sel_axis;
    logic [AXIS_W-1:0]        mag;
    logic [SQ_W-1:0]          prod;
    logic [AXIS_W-1:0]        root;

    // tracked state
    logic signed [AXIS_W-1:0] last_accel_reg [AXES];
    logic signed [AXIS_W-1:0] last_rate_reg  [AXES];
    logic [AXIS_W-1:0] peak_accel_reg, peak_accel_next;
    logic [AXIS_W-1:0] peak_rate_reg,  peak_rate_next;
    logic [AXIS_W-1:0] accel_count_reg, accel_count_next;
    logic [AXIS_W-1:0] rate_count_reg,  rate_count_next;
    logic [AXIS_W-1:0] accel_age_reg,   accel_age_next;
    logic [AXIS_W-1:0] rate_age_reg,    rate_age_next;
    logic              overrun_reg, overrun_next;
    logic              failure_reg, failure_next;
    logic              out_valid_reg, out_valid_next;
    logic              snap_valid;

    // decode the offered item for the controller
    always_comb
    begin
        sts.mode      = mode_t'(mode);
        sts.sample_ok = enable_reg && (tag == TAG_RATE || tag == TAG_ACCEL);
        sts.out_full  = out_valid_reg;
    end

    // take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            fresh_reg  <= FRESH_RESET;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                REG_ENABLE: enable_reg <= write_data[0];
                REG_FRESH:  fresh_reg  <= write_data;
            endcase
        end
    end

    // select one axis and square its magnitude
    always_comb
    begin
        unique case (cmd.axis_sel)
            AXIS_SEL_W'(0): sel_axis = axis_reg[0];
            AXIS_SEL_W'(1): sel_axis = axis_reg[1];
            default:        sel_axis = axis_reg[2];
        endcase
        mag  = sel_axis[AXIS_W-1] ? (~sel_axis + AXIS_W'(1)) : sel_axis;
        prod = SQ_W'(mag) * SQ_W'(mag);
    end

    // capture the sample and accumulate squares
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_accel_reg <= (tag == TAG_ACCEL);
            axis_reg[0]  <= axis_x;
            axis_reg[1]  <= axis_y;
            axis_reg[2]  <= axis_z;
            acc_reg      <= '0;
        end
        else if (cmd.mac)
        begin
            acc_reg <= acc_reg + prod;
        end
    end

    mpt_isqrt u_isqrt (
        .clk     (clk),
        .load    (cmd.root_load),
        .step    (cmd.root_step),
        .operand (acc_reg),
        .root    (root)
    );

    // keep the latest axes of each kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                last_accel_reg[i] <= '0;
                last_rate_reg[i]  <= '0;
            end
        end
        else if (cmd.capture)
        begin
            if (tag == TAG_ACCEL)
            begin
                last_accel_reg[0] <= axis_x;
                last_accel_reg[1] <= axis_y;
                last_accel_reg[2] <= axis_z;
            end
            else
            begin
                last_rate_reg[0] <= axis_x;
                last_rate_reg[1] <= axis_y;
                last_rate_reg[2] <= axis_z;
            end
        end
    end

    // snapshot qualifier
    assign snap_valid = enable_reg && !failure_reg &&
                        (accel_count_reg != '0) && (rate_count_reg != '0) &&
                        (accel_age_reg < fresh_reg) && (rate_age_reg < fresh_reg);

    // update peaks, counts, ages and latches
    always_comb
    begin
        peak_accel_next  = peak_accel_reg;
        peak_rate_next   = peak_rate_reg;
        accel_count_next = accel_count_reg;
        rate_count_next  = rate_count_reg;
        accel_age_next   = accel_age_reg;
        rate_age_next    = rate_age_reg;
        overrun_next     = overrun_reg;
        failure_next     = failure_reg;
        out_valid_next   = out_valid_reg && out_stall;

        if (cmd.commit)
        begin
            if (is_accel_reg)
            begin
                if (root > peak_accel_reg)
                    peak_accel_next = root;
                if (accel_count_reg != COUNT_MAX)
                    accel_count_next = accel_count_reg + AXIS_W'(1);
                accel_age_next = '0;
            end
            else
            begin
                if (root > peak_rate_reg)
                    peak_rate_next = root;
                if (rate_count_reg != COUNT_MAX)
                    rate_count_next = rate_count_reg + AXIS_W'(1);
                rate_age_next = '0;
            end
        end

        if (cmd.status && enable_reg)
        begin
            overrun_next = overrun_reg || overrun_flag;
            failure_next = failure_reg || bus_error;
        end

        if (cmd.tick)
        begin
            if (accel_age_reg != AGE_MAX)
                accel_age_next = accel_age_reg + AXIS_W'(1);
            if (rate_age_reg != AGE_MAX)
                rate_age_next = rate_age_reg + AXIS_W'(1);
        end

        // a report clears the peaks, counts and latches and raises out_valid
        if (cmd.report)
        begin
            peak_accel_next  = '0;
            peak_rate_next   = '0;
            accel_count_next = '0;
            rate_count_next  = '0;
            overrun_next     = 1'b0;
            failure_next     = 1'b0;
            out_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_accel_reg  <= '0;
            peak_rate_reg   <= '0;
            accel_count_reg <= '0;
            rate_count_reg  <= '0;
            accel_age_reg   <= AGE_MAX;
            rate_age_reg    <= AGE_MAX;
            overrun_reg     <= 1'b0;
            failure_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            peak_accel_reg  <= peak_accel_next;
            peak_rate_reg   <= peak_rate_next;
            accel_count_reg <= accel_count_next;
            rate_count_reg  <= rate_count_next;
            accel_age_reg   <= accel_age_next;
            rate_age_reg    <= rate_age_next;
            overrun_reg     <= overrun_next;
            failure_reg     <= failure_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // load the report register
    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            report_valid   <= snap_valid;
            accel_x        <= last_accel_reg[0];
            accel_y        <= last_accel_reg[1];
            accel_z        <= last_accel_reg[2];
            rate_x         <= last_rate_reg[0];
            rate_y         <= last_rate_reg[1];
            rate_z         <= last_rate_reg[2];
            peak_accel_mag <= peak_accel_reg;
            peak_rate_mag  <= peak_rate_reg;
            accel_samples  <= accel_count_reg;
            fifo_overrun   <= overrun_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/mpt_ctrl.sv */
// ----------------------------------------------------------------------------
// mpt_ctrl: controller of the motion peak tracker
// Accepts items, runs the square-accumulate and root steps of a sample, and
// issues one-cycle commands for status, tick and report items.
// ----------------------------------------------------------------------------
module mpt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          out_stall,
    input  mpt_pkg::sts_t sts,
    output mpt_pkg::cmd_t cmd
);
    import mpt_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.axis_sel = cnt_reg[AXIS_SEL_W-1:0];
        in_stall     = 1'b1;
        accept       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // hold a report while the previous one still waits
                in_stall = (sts.mode == MODE_REPORT) && sts.out_full && out_stall;
                accept   = in_valid && !in_stall;
                if (accept)
                begin
                    unique case (sts.mode)
                        MODE_SAMPLE:
                        begin
                            if (sts.sample_ok)
                            begin
                                cmd.capture = 1'b1;
                                cnt_next    = '0;
                                state_next  = ST_MAC;
                            end
                        end
                        MODE_STATUS: cmd.status = 1'b1;
                        MODE_TICK:   cmd.tick   = 1'b1;
                        MODE_REPORT: cmd.report = 1'b1;
                    endcase
                end
            end
            ST_MAC:
            begin
                cmd.mac = 1'b1;
                if (cnt_reg == CNT_W'(AXES - 1))
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_LOAD:
            begin
                cmd.root_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/imu_fifo_motion_peak_tracker.sv */
// ----------------------------------------------------------------------------
// imu_fifo_motion_peak_tracker: inertial FIFO motion peak tracker
// Tracks latest axes, peak magnitudes, sample counts and ages of acceleration
// and rotation samples, and emits a snapshot on each report request.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | mode, tag, axis_x/y/z, overrun_flag,
//           |                     | bus_error
//   out     | out_valid/out_stall | report_valid, accel_*, rate_*, peak_*,
//           |                     | accel_samples, fifo_overrun
//   config  | write_en            | reg_index, write_data
//
// A known-tag sample with the block enabled is accepted, squared and summed
// axis by axis through the single multiplier, loaded into the root unit,
// resolved in 16 root steps (one result bit each) and committed. Other items
// leave the controller idle. Any item is held off while a sample is in flight,
// a report also while the previous report waits under out_stall. Reset clears
// all tracked state; ages reset to their maximum, freshness limit to 200.
// ----------------------------------------------------------------------------
module imu_fifo_motion_peak_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic [mpt_pkg::TAG_W-1:0]         tag,
    input  logic signed [mpt_pkg::AXIS_W-1:0] axis_x,
    input  logic signed [mpt_pkg::AXIS_W-1:0] axis_y,
    input  logic signed [mpt_pkg::AXIS_W-1:0] axis_z,
    input  logic                              overrun_flag,
    input  logic                              bus_error,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              report_valid,
    output logic signed [mpt_pkg::AXIS_W-1:0] accel_x,
    output logic signed [mpt_pkg::AXIS_W-1:0] accel_y,
    output logic signed [mpt_pkg::AXIS_W-1:0] accel_z,
    output logic signed [mpt_pkg::AXIS_W-1:0] rate_x,
    output logic signed [mpt_pkg::AXIS_W-1:0] rate_y,
    output logic signed [mpt_pkg::AXIS_W-1:0] rate_z,
    output logic [mpt_pkg::AXIS_W-1:0]        peak_accel_mag,
    output logic [mpt_pkg::AXIS_W-1:0]        peak_rate_mag,
    output logic [mpt_pkg::AXIS_W-1:0]        accel_samples,
    output logic                              fifo_overrun,
    input  logic                              write_en,
    input  logic                              reg_index,
    input  logic [mpt_pkg::AXIS_W-1:0]        write_data
);
    import mpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mpt_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .write_en       (write_en),
        .reg_index      (reg_index),
        .write_data     (write_data),
        .mode           (mode),
        .tag            (tag),
        .axis_x         (axis_x),
        .axis_y         (axis_y),
        .axis_z         (axis_z),
        .overrun_flag   (overrun_flag),
        .bus_error      (bus_error),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .report_valid   (report_valid),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .rate_x         (rate_x),
        .rate_y         (rate_y),
        .rate_z         (rate_z),
        .peak_accel_mag (peak_accel_mag),
        .peak_rate_mag  (peak_rate_mag),
        .accel_samples  (accel_samples),
        .fifo_overrun   (fifo_overrun)
    );

endmodule

/* verif/imu_fifo_motion_peak_tracker_test.sv */
// ----------------------------------------------------------------------------
// imu_fifo_motion_peak_tracker_test: self-checking bench for the motion peak
// tracker
// Drives sample, status, tick and report transfers with random gaps and random
// receiver stalls. A shadow of the tracker state predicts every report
// snapshot, and each snapshot leaving the block is compared field by field.
// Directed runs cover the disabled block, unknown tags, the largest magnitude
// and the freshness boundary.
// ----------------------------------------------------------------------------
module imu_fifo_motion_peak_tracker_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mpt_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam int PRINT_LIMIT   = 200;

    // tags that the block must ignore
    localparam logic [TAG_W-1:0] TAG_UNUSED_ZERO = TAG_W'(0);
    localparam logic [TAG_W-1:0] TAG_UNUSED_MID  = TAG_W'(3);
    localparam logic [TAG_W-1:0] TAG_UNUSED_HIGH = TAG_W'(31);

    typedef struct {
        logic              report_valid;
        logic [AXIS_W-1:0] accel_x;
        logic [AXIS_W-1:0] accel_y;
        logic [AXIS_W-1:0] accel_z;
        logic [AXIS_W-1:0] rate_x;
        logic [AXIS_W-1:0] rate_y;
        logic [AXIS_W-1:0] rate_z;
        logic [AXIS_W-1:0] peak_accel;
        logic [AXIS_W-1:0] peak_rate;
        logic [AXIS_W-1:0] accel_count;
        logic              overrun;
    } snapshot_t;

    // ------------------------------------------------------------------------
    // Shadow of the tracker: predicts snapshots and checks the ones received
    // ------------------------------------------------------------------------
    class motion_tracker_shadow;
        logic              enabled;
        logic [AXIS_W-1:0] fresh_limit;
        logic [AXIS_W-1:0] accel_axes[AXES];
        logic [AXIS_W-1:0] rate_axes[AXES];
        logic [AXIS_W-1:0] accel_peak;
        logic [AXIS_W-1:0] rate_peak;
        logic [AXIS_W-1:0] accel_count;
        logic [AXIS_W-1:0] rate_count;
        logic [AXIS_W-1:0] accel_age;
        logic [AXIS_W-1:0] rate_age;
        logic              overrun_latched;
        logic              failure_latched;
        snapshot_t         expected_snapshots[$];
        int                errors;
        int                printed;

        function new();
            enabled         = 1'b0;
            fresh_limit     = AXIS_W'(200);
            accel_peak      = '0;
            rate_peak       = '0;
            accel_count     = '0;
            rate_count      = '0;
            accel_age       = AGE_MAX;
            rate_age        = AGE_MAX;
            overrun_latched = 1'b0;
            failure_latched = 1'b0;
            errors          = 0;
            printed         = 0;
            for (int i = 0; i < AXES; i++) begin
                accel_axes[i] = '0;
                rate_axes[i]  = '0;
            end
        endfunction

        function void write_reg(logic idx, logic [AXIS_W-1:0] data);
            if (idx == REG_ENABLE)
                enabled = data[0];
            else
                fresh_limit = data;
        endfunction

        // Floor square root, settled one result bit at a time from the top
        function logic [AXIS_W-1:0] floor_root(logic [SQ_W-1:0] energy);
            logic [AXIS_W-1:0] root;
            logic [AXIS_W-1:0] trial;
            longint unsigned   square;
            root = '0;
            for (int b = AXIS_W - 1; b >= 0; b--) begin
                trial  = root | (AXIS_W'(1) << b);
                square = longint'(trial) * longint'(trial);
                if (square <= longint'(energy))
                    root = trial;
            end
            return root;
        endfunction

        // Advance the shadow state by one accepted input transfer
        function void absorb_item(mode_t m, logic [TAG_W-1:0] t,
                                  logic signed [AXIS_W-1:0] x,
                                  logic signed [AXIS_W-1:0] y,
                                  logic signed [AXIS_W-1:0] z,
                                  logic ovr_flag, logic bus_flag);
            longint            ax;
            longint            ay;
            longint            az;
            longint            energy;
            logic [AXIS_W-1:0] mag;
            snapshot_t         snap;
            case (m)
                MODE_SAMPLE: begin
                    if (enabled && (t == TAG_ACCEL || t == TAG_RATE)) begin
                        ax     = x;
                        ay     = y;
                        az     = z;
                        energy = ax * ax + ay * ay + az * az;
                        mag    = floor_root(energy[SQ_W-1:0]);
                        if (t == TAG_ACCEL) begin
                            accel_axes[0] = x;
                            accel_axes[1] = y;
                            accel_axes[2] = z;
                            if (mag > accel_peak)
                                accel_peak = mag;
                            if (accel_count != COUNT_MAX)
                                accel_count++;
                            accel_age = '0;
                        end
                        else begin
                            rate_axes[0] = x;
                            rate_axes[1] = y;
                            rate_axes[2] = z;
                            if (mag > rate_peak)
                                rate_peak = mag;
                            if (rate_count != COUNT_MAX)
                                rate_count++;
                            rate_age = '0;
                        end
                    end
                end
                MODE_STATUS: begin
                    if (enabled) begin
                        overrun_latched = overrun_latched | ovr_flag;
                        failure_latched = failure_latched | bus_flag;
                    end
                end
                MODE_TICK: begin
                    if (accel_age != AGE_MAX)
                        accel_age++;
                    if (rate_age != AGE_MAX)
                        rate_age++;
                end
                default: begin
                    snap.report_valid = enabled && !failure_latched &&
                                        accel_count != 0 && rate_count != 0 &&
                                        accel_age < fresh_limit &&
                                        rate_age < fresh_limit;
                    snap.accel_x     = accel_axes[0];
                    snap.accel_y     = accel_axes[1];
                    snap.accel_z     = accel_axes[2];
                    snap.rate_x      = rate_axes[0];
                    snap.rate_y      = rate_axes[1];
                    snap.rate_z      = rate_axes[2];
                    snap.peak_accel  = accel_peak;
                    snap.peak_rate   = rate_peak;
                    snap.accel_count = accel_count;
                    snap.overrun     = overrun_latched;
                    expected_snapshots.push_back(snap);
                    // clear the per-report accumulators
                    accel_peak      = '0;
                    rate_peak       = '0;
                    accel_count     = '0;
                    rate_count      = '0;
                    overrun_latched = 1'b0;
                    failure_latched = 1'b0;
                end
            endcase
        endfunction

        function void report_error(string msg);
            errors++;
            if (printed < PRINT_LIMIT) begin
                printed++;
                $display("%0t: %s", $time, msg);
            end
        endfunction

        function void compare_field(string name, logic [AXIS_W-1:0] want,
                                    logic [AXIS_W-1:0] seen);
            if (want !== seen)
                report_error($sformatf("%s mismatch, expected %0h, actual %0h",
                                       name, want, seen));
        endfunction

        // Compare one received snapshot with the oldest prediction
        function void check_snapshot(snapshot_t seen);
            snapshot_t want;
            if (expected_snapshots.size() == 0) begin
                report_error("report transfer with no prediction pending");
                return;
            end
            want = expected_snapshots.pop_front();
            compare_field("report_valid", want.report_valid, seen.report_valid);
            compare_field("accel_x", want.accel_x, seen.accel_x);
            compare_field("accel_y", want.accel_y, seen.accel_y);
            compare_field("accel_z", want.accel_z, seen.accel_z);
            compare_field("rate_x", want.rate_x, seen.rate_x);
            compare_field("rate_y", want.rate_y, seen.rate_y);
            compare_field("rate_z", want.rate_z, seen.rate_z);
            compare_field("peak_accel_mag", want.peak_accel, seen.peak_accel);
            compare_field("peak_rate_mag", want.peak_rate, seen.peak_rate);
            compare_field("accel_samples", want.accel_count, seen.accel_count);
            compare_field("fifo_overrun", want.overrun, seen.overrun);
        endfunction

        function int outstanding();
            return expected_snapshots.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               mode;
    logic [TAG_W-1:0]         tag;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic                     overrun_flag;
    logic                     bus_error;
    logic                     out_valid;
    logic                     out_stall;
    logic                     report_valid;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] rate_x;
    logic signed [AXIS_W-1:0] rate_y;
    logic signed [AXIS_W-1:0] rate_z;
    logic [AXIS_W-1:0]        peak_accel_mag;
    logic [AXIS_W-1:0]        peak_rate_mag;
    logic [AXIS_W-1:0]        accel_samples;
    logic                     fifo_overrun;
    logic                     write_en;
    logic                     reg_index;
    logic [AXIS_W-1:0]        write_data;

    motion_tracker_shadow shadow;
    logic                 quiet;

    imu_fifo_motion_peak_tracker DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .tag            (tag),
        .axis_x         (axis_x),
        .axis_y         (axis_y),
        .axis_z         (axis_z),
        .overrun_flag   (overrun_flag),
        .bus_error      (bus_error),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .report_valid   (report_valid),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .rate_x         (rate_x),
        .rate_y         (rate_y),
        .rate_z         (rate_z),
        .peak_accel_mag (peak_accel_mag),
        .peak_rate_mag  (peak_rate_mag),
        .accel_samples  (accel_samples),
        .fifo_overrun   (fifo_overrun),
        .write_en       (write_en),
        .reg_index      (reg_index),
        .write_data     (write_data)
    );

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall in random bursts, none while quiet
    // ------------------------------------------------------------------------
    initial
    begin : receiver_stall
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                hold = 0;
            else if (hold == 0 && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 13);
            out_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    // Check each report transfer as it leaves the block
    always @(posedge clk)
    begin : report_watch
        snapshot_t seen;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            seen.report_valid = report_valid;
            seen.accel_x      = accel_x;
            seen.accel_y      = accel_y;
            seen.accel_z      = accel_z;
            seen.rate_x       = rate_x;
            seen.rate_y       = rate_y;
            seen.rate_z       = rate_z;
            seen.peak_accel   = peak_accel_mag;
            seen.peak_rate    = peak_rate_mag;
            seen.accel_count  = accel_samples;
            seen.overrun      = fifo_overrun;
            shadow.check_snapshot(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each starts and ends at a falling edge
    // ------------------------------------------------------------------------

    // Present one input transfer and hold it until accepted
    task automatic send_item(mode_t m, logic [TAG_W-1:0] t,
                             logic signed [AXIS_W-1:0] x,
                             logic signed [AXIS_W-1:0] y,
                             logic signed [AXIS_W-1:0] z,
                             logic ovr_flag, logic bus_flag);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        tag          <= t;
        axis_x       <= x;
        axis_y       <= y;
        axis_z       <= z;
        overrun_flag <= ovr_flag;
        bus_error    <= bus_flag;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        shadow.absorb_item(m, t, x, y, z, ovr_flag, bus_flag);
        @(negedge clk);
    endtask

    // Unused fields carry random noise
    task automatic send_sample(logic [TAG_W-1:0] t, logic signed [AXIS_W-1:0] x,
                               logic signed [AXIS_W-1:0] y,
                               logic signed [AXIS_W-1:0] z);
        send_item(MODE_SAMPLE, t, x, y, z, 1'($urandom), 1'($urandom));
    endtask

    task automatic send_status(logic ovr_flag, logic bus_flag);
        send_item(MODE_STATUS, TAG_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                  AXIS_W'($urandom), ovr_flag, bus_flag);
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, TAG_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                  AXIS_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_report();
        send_item(MODE_REPORT, TAG_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                  AXIS_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_tick();
    endtask

    // Drop valid, drain predicted reports and let a sample in flight finish
    task automatic settle();
        in_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [AXIS_W-1:0] data);
        write_en   <= 1'b1;
        reg_index  <= idx;
        write_data <= data;
        shadow.write_reg(idx, data);
        @(negedge clk);
        write_en <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------
    function automatic logic signed [AXIS_W-1:0] pick_axis();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return AXIS_W'($urandom_range(0, 64)) - AXIS_W'(32);
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    task automatic random_item();
        int               pick;
        logic [TAG_W-1:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 6) == 0)
                t = TAG_W'($urandom);
            else
                t = $urandom_range(0, 1) ? TAG_ACCEL : TAG_RATE;
            send_sample(t, pick_axis(), pick_axis(), pick_axis());
        end
        else if (pick < 55)
            send_status($urandom_range(0, 2) == 0, $urandom_range(0, 11) == 0);
        else if (pick < 80)
            send_tick();
        else
            send_report();
    endtask

    task automatic random_phase(int items, logic en, logic [AXIS_W-1:0] limit);
        settle();
        write_reg(REG_ENABLE, AXIS_W'(en));
        write_reg(REG_FRESH, limit);
        repeat (items) random_item();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_sequence
        shadow       = new();
        quiet        = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_TICK;
        tag          = '0;
        axis_x       = '0;
        axis_y       = '0;
        axis_z       = '0;
        overrun_flag = 1'b0;
        bus_error    = 1'b0;
        write_en     = 1'b0;
        reg_index    = REG_ENABLE;
        write_data   = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // disabled block: samples and status ignored, report still clears
        write_reg(REG_ENABLE, AXIS_W'(0));
        write_reg(REG_FRESH, AXIS_W'(200));
        send_sample(TAG_ACCEL, 16'sd100, -16'sd200, 16'sd300);
        send_status(1'b1, 1'b1);
        send_tick();
        send_report();

        // enabled: extremes, unknown tags, latches and clearing
        settle();
        write_reg(REG_ENABLE, AXIS_W'(1));
        send_sample(TAG_ACCEL, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(TAG_RATE, 16'sh7FFF, 16'sh8000, 16'sd0);
        send_sample(TAG_UNUSED_ZERO, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(TAG_UNUSED_MID, 16'sd5, 16'sd6, 16'sd7);
        send_sample(TAG_UNUSED_HIGH, -16'sd1, -16'sd1, -16'sd1);
        send_sample(TAG_ACCEL, 16'sd0, 16'sd0, 16'sd0);
        send_status(1'b1, 1'b0);
        send_tick();
        send_report();
        send_report();
        send_sample(TAG_ACCEL, 16'sd1, -16'sd1, 16'sd1);
        send_sample(TAG_RATE, 16'sd100, 16'sd200, -16'sd300);
        send_status(1'b0, 1'b1);
        send_report();
        send_report();

        // freshness boundary: age one below the limit, then at the limit
        send_sample(TAG_ACCEL, 16'sd3, 16'sd4, 16'sd12);
        send_sample(TAG_RATE, -16'sd3, 16'sd4, -16'sd12);
        send_ticks(199);
        send_report();
        send_sample(TAG_ACCEL, 16'sd30, 16'sd40, 16'sd0);
        send_sample(TAG_RATE, 16'sd0, -16'sd30, 16'sd40);
        send_ticks(200);
        send_report();

        // random phases over several register settings
        random_phase(150, 1'b1, AXIS_W'(200));
        random_phase(100, 1'b1, AXIS_W'(1));
        random_phase(100, 1'b0, AXIS_W'($urandom_range(1, 65535)));
        random_phase(140, 1'b1, AXIS_W'($urandom_range(2, 40)));
        settle();
        quiet = 1'b1;
        random_phase(140, 1'b1, AXIS_W'(65535));

        settle();
        if (shadow.errors == 0 && shadow.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
